FILE: rtl/fcs_pkg.sv
// shared widths, payload types and constants of the filled circle span generator
package fcs_pkg;

    localparam int unsigned COORD_W     = 12;
    localparam int unsigned SPAN_W      = 13;
    localparam int unsigned RADIUS_W    = 6;
    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned STEP_W      = 8;
    localparam int unsigned ERR_W       = 10;
    localparam int unsigned MAX_GROUPS  = 46;
    localparam int unsigned GROUP_CNT_W = 6;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_LVL_W = 2;

    // one circle as it travels from the front to the back
    typedef struct packed {
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic        [RADIUS_W-1:0] radius;
        logic        [COLOR_W-1:0]  color;
    } t_circle;

    // status of the span back end
    typedef struct packed {
        logic                   busy;
        logic [GROUP_CNT_W-1:0] groups;
    } t_back_stat;

endpackage

FILE: rtl/fcs_if.sv
// request channels: circle in, span group out

interface fcs_circle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fcs_pkg::COORD_W-1:0]   center_x;
    logic signed [fcs_pkg::COORD_W-1:0]   center_y;
    logic        [fcs_pkg::RADIUS_W-1:0]  circle_radius;
    logic        [fcs_pkg::COLOR_W-1:0]   fill_color;

    modport source (output valid, center_x, center_y, circle_radius, fill_color,
                    input ready);
    modport sink   (input valid, center_x, center_y, circle_radius, fill_color,
                    output ready);
endinterface

interface fcs_span_if;
    logic                               valid;
    logic                               ready;
    logic signed [fcs_pkg::SPAN_W-1:0]  wide_left;
    logic signed [fcs_pkg::SPAN_W-1:0]  wide_right;
    logic signed [fcs_pkg::SPAN_W-1:0]  wide_row_low;
    logic signed [fcs_pkg::SPAN_W-1:0]  wide_row_high;
    logic signed [fcs_pkg::SPAN_W-1:0]  narrow_left;
    logic signed [fcs_pkg::SPAN_W-1:0]  narrow_right;
    logic signed [fcs_pkg::SPAN_W-1:0]  narrow_row_low;
    logic signed [fcs_pkg::SPAN_W-1:0]  narrow_row_high;
    logic        [fcs_pkg::COLOR_W-1:0] span_color;
    logic                               last_group;

    modport source (output valid, wide_left, wide_right, wide_row_low, wide_row_high,
                    narrow_left, narrow_right, narrow_row_low, narrow_row_high,
                    span_color, last_group,
                    input ready);
    modport sink   (input valid, wide_left, wide_right, wide_row_low, wide_row_high,
                    narrow_left, narrow_right, narrow_row_low, narrow_row_high,
                    span_color, last_group,
                    output ready);
endinterface

FILE: rtl/fcs_front.sv
// front end: takes circle requests, saturates the radius, registers the circle
module fcs_front #(
    parameter int unsigned MAX_RADIUS = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fcs_circle_if.sink         i_circle,
    output logic               o_valid,
    output fcs_pkg::t_circle   o_item,
    input  logic               i_ready
);

    localparam logic [fcs_pkg::RADIUS_W:0] RADIUS_LIM = (fcs_pkg::RADIUS_W+1)'(MAX_RADIUS);

    logic             r_valid;
    fcs_pkg::t_circle r_item;
    fcs_pkg::t_circle n_item;

    // stage is free when empty or when the queue takes its content
    assign i_circle.ready = !r_valid || i_ready;

    // radius saturation
    always_comb begin
        n_item.cx     = i_circle.center_x;
        n_item.cy     = i_circle.center_y;
        n_item.color  = i_circle.fill_color;
        n_item.radius = i_circle.circle_radius;
        if ({1'b0, i_circle.circle_radius} > RADIUS_LIM) begin
            n_item.radius = RADIUS_LIM[fcs_pkg::RADIUS_W-1:0];
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_circle.ready) begin
            r_valid <= i_circle.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_circle.valid && i_circle.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/fcs_queue.sv
// short circle queue between front and back end
module fcs_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  fcs_pkg::t_circle                    i_item,
    output logic                                o_ready,
    output logic                                o_valid,
    output fcs_pkg::t_circle                    o_item,
    input  logic                                i_ready,
    output logic [fcs_pkg::QUEUE_LVL_W-1:0]     o_level
);

    fcs_pkg::t_circle                  r_mem [fcs_pkg::QUEUE_DEPTH];
    logic                              r_wr_ptr;
    logic                              r_rd_ptr;
    logic [fcs_pkg::QUEUE_LVL_W-1:0]   r_level;
    logic                              push;
    logic                              pop;

    assign o_ready = (r_level != fcs_pkg::QUEUE_LVL_W'(fcs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_level != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            priority if (push && !pop) begin
                r_level <= r_level + 1'b1;
            end else if (pop && !push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    assign o_level = r_level;

endmodule

FILE: rtl/fcs_back.sv
// back end: midpoint circle recurrence, one span group per cycle unless the output stalls, into an output register
module fcs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  fcs_pkg::t_circle      i_item,
    output logic                  o_ready,
    fcs_span_if.source            o_span,
    output fcs_pkg::t_back_stat   o_stat
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_back_state;

    t_back_state                          r_state;
    logic signed [fcs_pkg::COORD_W-1:0]   r_cx;
    logic signed [fcs_pkg::COORD_W-1:0]   r_cy;
    logic        [fcs_pkg::COLOR_W-1:0]   r_color;
    logic signed [fcs_pkg::STEP_W-1:0]    r_x;
    logic signed [fcs_pkg::STEP_W-1:0]    r_y;
    logic signed [fcs_pkg::ERR_W-1:0]     r_err;
    logic        [fcs_pkg::GROUP_CNT_W-1:0] r_groups;
    logic                                 r_out_valid;

    logic                                 take;
    logic                                 advance;
    logic signed [fcs_pkg::STEP_W-1:0]    n_y;
    logic signed [fcs_pkg::STEP_W-1:0]    x_dec;
    logic signed [fcs_pkg::STEP_W-1:0]    n_x;
    logic signed [fcs_pkg::ERR_W-1:0]     err_add;
    logic signed [fcs_pkg::ERR_W-1:0]     n_err;
    logic                                 last;
    logic signed [fcs_pkg::SPAN_W-1:0]    cx_ext;
    logic signed [fcs_pkg::SPAN_W-1:0]    cy_ext;
    logic signed [fcs_pkg::SPAN_W-1:0]    x_ext;
    logic signed [fcs_pkg::SPAN_W-1:0]    y_ext;

    assign o_ready = (r_state == ST_IDLE);
    assign take    = o_ready && i_valid;
    assign advance = (r_state == ST_RUN) && (!r_out_valid || o_span.ready);

    // recurrence step
    always_comb begin
        n_y     = r_y + 1'b1;
        x_dec   = r_x - 1'b1;
        err_add = r_err;
        if (r_err <= 0) begin
            err_add = r_err + $signed({1'b0, n_y, 1'b1});
        end
        n_x   = r_x;
        n_err = err_add;
        if (err_add > 0) begin
            n_x   = x_dec;
            n_err = err_add - $signed({x_dec[fcs_pkg::STEP_W-1], x_dec, 1'b1});
        end
        last = (n_x < n_y) ||
               (r_groups == fcs_pkg::GROUP_CNT_W'(fcs_pkg::MAX_GROUPS - 1));
    end

    // operands widened to span width
    assign cx_ext = {r_cx[fcs_pkg::COORD_W-1], r_cx};
    assign cy_ext = {r_cy[fcs_pkg::COORD_W-1], r_cy};
    assign x_ext  = {{(fcs_pkg::SPAN_W-fcs_pkg::STEP_W){r_x[fcs_pkg::STEP_W-1]}}, r_x};
    assign y_ext  = {{(fcs_pkg::SPAN_W-fcs_pkg::STEP_W){r_y[fcs_pkg::STEP_W-1]}}, r_y};

    // control: sequencer, group count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_groups    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_state  <= ST_RUN;
                        r_groups <= '0;
                    end
                end
                ST_RUN: begin
                    if (advance) begin
                        r_groups <= r_groups + 1'b1;
                        if (last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_span.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // circle and iteration registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cx    <= i_item.cx;
            r_cy    <= i_item.cy;
            r_color <= i_item.color;
            r_x     <= $signed({{(fcs_pkg::STEP_W-fcs_pkg::RADIUS_W){1'b0}}, i_item.radius});
            r_y     <= '0;
            r_err   <= '0;
        end else if (advance) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_span.wide_left       <= cx_ext - x_ext;
            o_span.wide_right      <= cx_ext + x_ext;
            o_span.wide_row_low    <= cy_ext + y_ext;
            o_span.wide_row_high   <= cy_ext - y_ext;
            o_span.narrow_left     <= cx_ext - y_ext;
            o_span.narrow_right    <= cx_ext + y_ext;
            o_span.narrow_row_low  <= cy_ext + x_ext;
            o_span.narrow_row_high <= cy_ext - x_ext;
            o_span.span_color      <= r_color;
            o_span.last_group      <= last;
        end
    end

    assign o_span.valid  = r_out_valid;
    assign o_stat.busy   = (r_state == ST_RUN);
    assign o_stat.groups = r_groups;

endmodule

FILE: rtl/filled_circle_span_generator_top.sv
// top level of the filled circle span generator
//
//  channel    dir  request                        payload
//  i_circle   in   one circle                     center_x, center_y, circle_radius, fill_color
//  o_span     out  one span group (four spans)    wide_*, narrow_*, span_color, last_group
//
//  a circle of radius r gives about r/1.41 + 1 groups (at most 46), one per cycle unless the
//  output stalls, from the back end's recurrence register loop, which idles to load the next circle from the queue
//  the front stage and a two-entry queue keep taking circles while the back end works
//  a stalled output holds the back end; the queue fills and then the input stalls
//  reset (i_rst_n low, synchronous) empties the front stage, queue and output register
module filled_circle_span_generator_top #(
    parameter int unsigned MAX_RADIUS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcs_circle_if.sink  i_circle,
    fcs_span_if.source  o_span
);

    logic                               front_valid;
    fcs_pkg::t_circle                   front_item;
    logic                               queue_ready;
    logic                               queue_valid;
    fcs_pkg::t_circle                   queue_item;
    logic                               back_ready;
    logic [fcs_pkg::QUEUE_LVL_W-1:0]    queue_level;
    fcs_pkg::t_back_stat                back_stat;

    // request intake and radius saturation
    fcs_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_circle (i_circle),
        .o_valid  (front_valid),
        .o_item   (front_item),
        .i_ready  (queue_ready)
    );

    // decoupling queue
    fcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_ready (back_ready),
        .o_level (queue_level)
    );

    // span group generation
    fcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_ready (back_ready),
        .o_span  (o_span),
        .o_stat  (back_stat)
    );

`ifndef NO_ASSERTIONS
    // queue never overfills
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_level <= fcs_pkg::QUEUE_LVL_W'(fcs_pkg::QUEUE_DEPTH))
        else $error("circle queue over its depth");

    // group count stays below the per-circle limit while running
    a_group_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.busy |-> (back_stat.groups < fcs_pkg::GROUP_CNT_W'(fcs_pkg::MAX_GROUPS)))
        else $error("group count past limit");

    // an idle back end only holds the closing group of a circle
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!back_stat.busy && o_span.valid) |-> o_span.last_group)
        else $error("idle with an unfinished circle");

    // a newly started circle begins with a fresh group count
    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(back_stat.busy) |-> (back_stat.groups == '0))
        else $error("group count not cleared at circle start");
`endif

endmodule

FILE: dv/tb_filled_circle_span_generator_top.sv
// testbench of the filled circle span generator: directed and random circles, checked per span group
`timescale 1ns / 100ps

module tb_filled_circle_span_generator_top;

    localparam int unsigned CIRCLE_MAX_RADIUS = 63;
    localparam int          RANDOM_CIRCLES    = 380;
    localparam int          TAIL_CYCLES       = 64;

    // one span group as the block should present it
    typedef struct {
        logic signed [fcs_pkg::SPAN_W-1:0]  wide_left;
        logic signed [fcs_pkg::SPAN_W-1:0]  wide_right;
        logic signed [fcs_pkg::SPAN_W-1:0]  wide_row_low;
        logic signed [fcs_pkg::SPAN_W-1:0]  wide_row_high;
        logic signed [fcs_pkg::SPAN_W-1:0]  narrow_left;
        logic signed [fcs_pkg::SPAN_W-1:0]  narrow_right;
        logic signed [fcs_pkg::SPAN_W-1:0]  narrow_row_low;
        logic signed [fcs_pkg::SPAN_W-1:0]  narrow_row_high;
        logic        [fcs_pkg::COLOR_W-1:0] span_color;
        logic                               last_group;
    } t_span_group;

    logic i_clk;
    logic i_rst_n;

    fcs_circle_if circle_if ();
    fcs_span_if   span_if ();

    t_span_group pending_groups[$];
    int          mismatch_count;
    bit          sink_free_run;

    filled_circle_span_generator_top #(
        .MAX_RADIUS (CIRCLE_MAX_RADIUS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_circle (circle_if),
        .o_span   (span_if)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // midpoint recurrence: queue every span group that one circle gives
    function automatic void plot_circle_groups(input fcs_pkg::t_circle c);
        t_span_group g;
        int          cx;
        int          cy;
        int          x;
        int          y;
        int          err;
        int          groups;
        bit          done;
        cx     = c.cx;
        cy     = c.cy;
        x      = (c.radius > CIRCLE_MAX_RADIUS) ? CIRCLE_MAX_RADIUS : int'(c.radius);
        y      = 0;
        err    = 0;
        groups = 0;
        done   = 1'b0;
        while (!done) begin
            g.wide_left       = fcs_pkg::SPAN_W'(cx - x);
            g.wide_right      = fcs_pkg::SPAN_W'(cx + x);
            g.wide_row_low    = fcs_pkg::SPAN_W'(cy + y);
            g.wide_row_high   = fcs_pkg::SPAN_W'(cy - y);
            g.narrow_left     = fcs_pkg::SPAN_W'(cx - y);
            g.narrow_right    = fcs_pkg::SPAN_W'(cx + y);
            g.narrow_row_low  = fcs_pkg::SPAN_W'(cy + x);
            g.narrow_row_high = fcs_pkg::SPAN_W'(cy - x);
            g.span_color      = c.color;
            groups++;
            y++;
            if (err <= 0) begin
                err += 2 * y + 1;
            end
            if (err > 0) begin
                x--;
                err -= 2 * x + 1;
            end
            done         = (x < y) || (groups >= fcs_pkg::MAX_GROUPS);
            g.last_group = done;
            pending_groups.push_back(g);
        end
    endfunction

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic void compare_field(input string name, input logic signed [31:0] want,
                                          input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // send one circle request after a gap, predicting on acceptance
    task automatic send_circle(input fcs_pkg::t_circle c, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            circle_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        circle_if.valid         <= 1'b1;
        circle_if.center_x      <= c.cx;
        circle_if.center_y      <= c.cy;
        circle_if.circle_radius <= c.radius;
        circle_if.fill_color    <= c.color;
        do begin
            @(posedge i_clk);
        end while (circle_if.ready !== 1'b1);
        plot_circle_groups(c);
    endtask

    task automatic send_fields(input int cx, input int cy, input int radius, input int color,
                               input int gap);
        fcs_pkg::t_circle c;
        c.cx     = fcs_pkg::COORD_W'(cx);
        c.cy     = fcs_pkg::COORD_W'(cy);
        c.radius = fcs_pkg::RADIUS_W'(radius);
        c.color  = fcs_pkg::COLOR_W'(color);
        send_circle(c, gap);
    endtask

    function automatic fcs_pkg::t_circle random_circle();
        fcs_pkg::t_circle c;
        int               roll;
        c.cx    = fcs_pkg::COORD_W'($urandom());
        c.cy    = fcs_pkg::COORD_W'($urandom());
        c.color = fcs_pkg::COLOR_W'($urandom());
        roll    = $urandom_range(0, 99);
        if (roll < 60) begin
            c.radius = fcs_pkg::RADIUS_W'($urandom_range(0, 63));
        end else if (roll < 85) begin
            c.radius = fcs_pkg::RADIUS_W'($urandom_range(0, 8));
        end else begin
            c.radius = fcs_pkg::RADIUS_W'($urandom_range(56, 63));
        end
        return c;
    endfunction

    task automatic wait_until_drained();
        while (pending_groups.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // field extremes, zero radius, smallest radii, duplicated centre row
    task automatic test_corner_circles();
        send_fields(0, 0, 0, 'h000000, 0);
        send_fields(-2048, -2048, 0, 'hFFFFFF, 0);
        send_fields(2047, 2047, 0, 'hAAAAAA, 1);
        send_fields(0, 0, 1, 'h555555, 0);
        send_fields(10, -10, 2, 'h123456, 0);
        send_fields(-1, 1, 3, 'hFF0000, 2);
        send_fields(-2048, -2048, 63, 'h00FF00, 0);
        send_fields(2047, 2047, 63, 'h0000FF, 0);
        send_fields(-2048, 2047, 63, 'hFFFFFF, 0);
        send_fields(2047, -2048, 63, 'h000000, 5);
        send_fields(0, 0, 32, 'h800001, 0);
        send_fields(-1, -1, 31, 'h7FFFFE, 0);
        send_fields(2047, 0, 62, 'hC0FFEE, 0);
        send_fields(0, -2048, 1, 'hFFFFFF, 0);
        send_fields(1024, -1024, 7, 'h0F0F0F, 1);
        send_fields(-1025, 1023, 16, 'hF0F0F0, 0);
    endtask

    // input held off until every queued span group has come out
    task automatic test_drain_pause();
        fcs_pkg::t_circle c;
        repeat (6) begin
            c = random_circle();
            send_circle(c, 0);
        end
        @(negedge i_clk);
        circle_if.valid <= 1'b0;
        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        repeat (6) begin
            c        = random_circle();
            c.radius = fcs_pkg::RADIUS_W'($urandom_range(0, 4));
            send_circle(c, 0);
        end
    endtask

    // random circles with random gaps and runs of back-to-back requests
    task automatic test_random_circles();
        fcs_pkg::t_circle c;
        int               burst;
        int               sent;
        sent = 0;
        while (sent < RANDOM_CIRCLES) begin
            burst = $urandom_range(1, 30);
            if (burst > RANDOM_CIRCLES - sent) begin
                burst = RANDOM_CIRCLES - sent;
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat (burst) begin
                    c = random_circle();
                    send_circle(c, 0);
                    sent++;
                end
            end else begin
                repeat (burst) begin
                    c = random_circle();
                    send_circle(c, pick_gap());
                    sent++;
                end
            end
        end
        @(negedge i_clk);
        circle_if.valid <= 1'b0;
    endtask

    // output side: random stalls with occasional free-running stretches
    initial begin
        int hold;
        int stall;
        span_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (sink_free_run || $urandom_range(0, 9) == 0) begin
                repeat (100) begin
                    @(negedge i_clk);
                    span_if.ready <= 1'b1;
                end
            end else begin
                hold  = $urandom_range(1, 8);
                stall = pick_gap();
                repeat (hold) begin
                    @(negedge i_clk);
                    span_if.ready <= 1'b1;
                end
                repeat (stall) begin
                    @(negedge i_clk);
                    span_if.ready <= 1'b0;
                end
            end
        end
    end

    // compare each span group with the oldest prediction
    always @(posedge i_clk) begin
        t_span_group want;
        if (i_rst_n && span_if.valid === 1'b1 && span_if.ready === 1'b1) begin
            if (pending_groups.size() == 0) begin
                $error("span group with no circle pending");
                mismatch_count++;
            end else begin
                want = pending_groups.pop_front();
                compare_field("wide_left", want.wide_left, span_if.wide_left);
                compare_field("wide_right", want.wide_right, span_if.wide_right);
                compare_field("wide_row_low", want.wide_row_low, span_if.wide_row_low);
                compare_field("wide_row_high", want.wide_row_high, span_if.wide_row_high);
                compare_field("narrow_left", want.narrow_left, span_if.narrow_left);
                compare_field("narrow_right", want.narrow_right, span_if.narrow_right);
                compare_field("narrow_row_low", want.narrow_row_low, span_if.narrow_row_low);
                compare_field("narrow_row_high", want.narrow_row_high,
                              span_if.narrow_row_high);
                compare_field("span_color", want.span_color, span_if.span_color);
                compare_field("last_group", want.last_group, span_if.last_group);
            end
        end
    end

    // overall time limit
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // reset, tests in turn, drain and verdict
    initial begin
        mismatch_count          = 0;
        sink_free_run           = 1'b0;
        i_rst_n                 = 1'b0;
        circle_if.valid         = 1'b0;
        circle_if.center_x      = '0;
        circle_if.center_y      = '0;
        circle_if.circle_radius = '0;
        circle_if.fill_color    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_circles();
        test_drain_pause();
        test_random_circles();

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_groups.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
